FILE: rtl/core/psll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psll_pkg: shared types and constants for the pooled sorted linked list
// Holds operation and status codes, widths and the request record.
// ----------------------------------------------------------------------------
package psll_pkg;

    localparam int NODES_DEF   = 256;
    localparam int ID_W        = 8;
    localparam int VAL_W       = 32;
    localparam logic [VAL_W-1:0] SENTINEL_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_ADD_HEAD   = 3'd0,
        OP_ADD_TAIL   = 3'd1,
        OP_ADD_SORTED = 3'd2,
        OP_ADD_AFTER  = 3'd3,
        OP_REM_ID     = 3'd4,
        OP_REM_HEAD   = 3'd5,
        OP_REM_TAIL   = 3'd6,
        OP_READ       = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_ID  = 2'd2;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] item_value;
        logic [VAL_W-1:0] sort_key;
        logic [ID_W-1:0]  node_id;
        logic             id_range_ok;
    } req_t;

endpackage

FILE: rtl/core/psll_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psll_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/psll_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psll_front: request intake and queue
// Accepts requests, flags out-of-range ids and holds them in a small FIFO.
// ----------------------------------------------------------------------------
module psll_front
    import psll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_req,
    output logic       q_valid,
    input  logic       q_ready,
    output req_t       q_req
);

    localparam int QD = 2;

    req_t       slot_reg [QD];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t       req_c;

    always_comb
    begin
        req_c = in_req;
        req_c.id_range_ok = ({1'b0, in_req.node_id} < (ID_W+1)'(NODES));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg[wp_reg] <= req_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_valid && q_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end

endmodule

FILE: rtl/core/psll_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psll_back: list engine
// Runs one request at a time over the link and value memories: free-slot
// search, sorted walk, relinking and the max/min walk, then registers a result.
// ----------------------------------------------------------------------------
module psll_back
    import psll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  req_t             q_req,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  result_id,
    output logic [VAL_W-1:0] read_value,
    output logic [ID_W-1:0]  read_next,
    output logic [ID_W-1:0]  read_prior,
    output logic [ID_W-1:0]  head_id,
    output logic [ID_W-1:0]  node_count,
    output logic [ID_W-1:0]  max_id,
    output logic [ID_W-1:0]  min_id
);

    localparam int AW = $clog2(NODES);

    typedef enum logic [4:0] {
        S_IDLE, S_RD_HT, S_CHK, S_FREE, S_WALK_RD, S_WALK_CHK, S_ANC_RD,
        S_ANC, S_LINK1, S_LINK2, S_LINK3, S_TGT_RD, S_TGT, S_UNL1, S_UNL2,
        S_EX_RD, S_EX_CHK, S_READ_RD, S_READ, S_DONE
    } state_t;

    state_t            state_reg;
    req_t              req_reg;
    logic [NODES-1:0]  valid_reg;
    logic [ID_W-1:0]   count_reg, largest_reg, smallest_reg, head_reg, tail_reg;
    logic [ID_W-1:0]   slot_reg, anchor_reg, cur_reg, nx_reg, pv_reg;
    logic [AW:0]       steps_reg;
    logic [VAL_W-1:0]  hi_reg, lo_reg;
    logic [ID_W-1:0]   hid_reg, lid_reg;
    logic              out_valid_reg;
    // working copy of the result; the output copy holds until accepted
    logic [1:0]        st_reg;
    logic [ID_W-1:0]   rid_reg, rnx_reg, rpv_reg;
    logic [VAL_W-1:0]  rval_reg;

    // link memories: one write and one read a cycle each
    logic            nl_we, pl_we, nv_we;
    logic [AW-1:0]   nl_wa, pl_wa, nv_wa, nl_ra, pl_ra, nv_ra;
    logic [ID_W-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
    logic [VAL_W-1:0] nv_wd, nv_rd;

    psll_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_next (
        .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));
    psll_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_prior (
        .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
    psll_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_value (
        .clk(clk), .we(nv_we), .waddr(nv_wa), .wdata(nv_wd), .raddr(nv_ra), .rdata(nv_rd));

    // entries with a clear valid bit read as zero links; sentinel value is constant
    logic [ID_W-1:0]  nl_q, pl_q;
    logic [VAL_W-1:0] nv_q;
    logic             rd_ok_reg, rd_zero_reg;
    assign nl_q = rd_ok_reg ? nl_rd : '0;
    assign pl_q = rd_ok_reg ? pl_rd : '0;
    assign nv_q = rd_zero_reg ? SENTINEL_VALUE : nv_rd;

    logic [ID_W-1:0] rd_addr;
    logic [ID_W-1:0] tgt_c;

    assign nl_ra = rd_addr[AW-1:0];
    assign pl_ra = rd_addr[AW-1:0];
    assign nv_ra = rd_addr[AW-1:0];

    always_comb
    begin
        rd_addr = cur_reg;
        nl_we = 1'b0; pl_we = 1'b0; nv_we = 1'b0;
        nl_wa = '0; pl_wa = '0; nv_wa = '0;
        nl_wd = '0; pl_wd = '0; nv_wd = req_reg.item_value;
        unique case (state_reg)
            S_READ_RD: rd_addr = req_reg.node_id;
            S_ANC_RD:  rd_addr = cur_reg;
            S_LINK1:
            begin
                // new node: next = n, prior = anchor
                nl_we = 1'b1; nl_wa = slot_reg[AW-1:0]; nl_wd = nx_reg;
                pl_we = 1'b1; pl_wa = slot_reg[AW-1:0]; pl_wd = anchor_reg;
                nv_we = 1'b1; nv_wa = slot_reg[AW-1:0];
            end
            S_LINK2:
            begin
                nl_we = 1'b1; nl_wa = anchor_reg[AW-1:0]; nl_wd = slot_reg;
                pl_we = 1'b1; pl_wa = nx_reg[AW-1:0];     pl_wd = slot_reg;
            end
            S_UNL1:
            begin
                nl_we = 1'b1; nl_wa = pv_reg[AW-1:0]; nl_wd = nx_reg;
                pl_we = 1'b1; pl_wa = nx_reg[AW-1:0]; pl_wd = pv_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        tgt_c = req_reg.node_id;
        if (req_reg.op == OP_REM_HEAD) tgt_c = head_reg;
        if (req_reg.op == OP_REM_TAIL) tgt_c = tail_reg;
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= NODES'(1);
            count_reg     <= '0;
            largest_reg   <= '0;
            smallest_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            rd_zero_reg   <= 1'b0;
        end
        else
        begin
            rd_ok_reg   <= valid_reg[rd_addr[AW-1:0]];
            rd_zero_reg <= (rd_addr == '0);
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg   <= q_req;
                        st_reg    <= ST_OK;
                        rid_reg   <= '0;
                        rval_reg  <= '0;
                        rnx_reg   <= '0;
                        rpv_reg   <= '0;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (req_reg.op == OP_READ)
                    begin
                        if (!req_reg.id_range_ok || !valid_reg[req_reg.node_id[AW-1:0]])
                        begin
                            st_reg <= ST_BAD_ID; state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_READ_RD;
                        end
                    end
                    else if (req_reg.op == OP_REM_ID || req_reg.op == OP_REM_HEAD ||
                             req_reg.op == OP_REM_TAIL)
                    begin
                        if (tgt_c == '0 || ({1'b0, tgt_c} >= (ID_W+1)'(NODES)) ||
                            !valid_reg[tgt_c[AW-1:0]])
                        begin
                            st_reg <= ST_BAD_ID; state_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg <= tgt_c; state_reg <= S_TGT_RD;
                        end
                    end
                    else if (req_reg.op == OP_ADD_AFTER &&
                             (!req_reg.id_range_ok || !valid_reg[req_reg.node_id[AW-1:0]]))
                    begin
                        st_reg <= ST_BAD_ID; state_reg <= S_DONE;
                    end
                    else
                    begin
                        slot_reg  <= ID_W'(1);
                        state_reg <= S_FREE;
                    end
                end
                S_FREE:
                begin
                    // scan one slot a cycle for the lowest free one
                    if (!valid_reg[slot_reg[AW-1:0]])
                    begin
                        steps_reg <= '0;
                        unique case (req_reg.op)
                            OP_ADD_TAIL:
                            begin
                                anchor_reg <= tail_reg; cur_reg <= tail_reg;
                                state_reg <= S_ANC_RD;
                            end
                            OP_ADD_SORTED:
                            begin
                                cur_reg <= head_reg; state_reg <= S_WALK_RD;
                            end
                            OP_ADD_AFTER:
                            begin
                                anchor_reg <= req_reg.node_id; cur_reg <= req_reg.node_id;
                                state_reg <= S_ANC_RD;
                            end
                            default:
                            begin
                                anchor_reg <= '0; cur_reg <= '0; state_reg <= S_ANC_RD;
                            end
                        endcase
                    end
                    else if ({1'b0, slot_reg} >= (ID_W+1)'(NODES - 1))
                    begin
                        st_reg <= ST_FULL; state_reg <= S_DONE;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + ID_W'(1);
                    end
                end
                S_WALK_RD:
                begin
                    if (steps_reg >= (AW+1)'(NODES) || cur_reg == '0)
                    begin
                        // anchor is the prior of the stop node
                        state_reg <= S_RD_HT;
                    end
                    else
                    begin
                        state_reg <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK:
                begin
                    if (req_reg.sort_key > nv_q)
                    begin
                        cur_reg   <= nl_q;
                        steps_reg <= steps_reg + (AW+1)'(1);
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        state_reg <= S_RD_HT;
                    end
                end
                S_RD_HT:
                begin
                    // read prior of the stop node next cycle
                    state_reg <= S_ANC;
                    anchor_reg <= '0;
                end
                S_ANC:
                begin
                    anchor_reg <= (cur_reg == '0) ? tail_reg : pl_q;
                    cur_reg    <= (cur_reg == '0) ? tail_reg : pl_q;
                    state_reg  <= S_ANC_RD;
                end
                S_ANC_RD:
                begin
                    state_reg <= S_LINK3;
                end
                S_LINK3:
                begin
                    nx_reg    <= (anchor_reg == '0) ? head_reg : nl_q;
                    state_reg <= S_LINK1;
                end
                S_LINK1:
                begin
                    valid_reg[slot_reg[AW-1:0]] <= 1'b1;
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    if (anchor_reg == '0) head_reg <= slot_reg;
                    if (nx_reg == '0)     tail_reg <= slot_reg;
                    count_reg <= count_reg + ID_W'(1);
                    rid_reg   <= slot_reg;
                    state_reg <= S_EX_RD;
                    cur_reg   <= (anchor_reg == '0) ? slot_reg : head_reg;
                    steps_reg <= '0;
                end
                S_TGT_RD:
                begin
                    state_reg <= S_TGT;
                end
                S_TGT:
                begin
                    nx_reg <= nl_q; pv_reg <= pl_q;
                    state_reg <= S_UNL1;
                end
                S_UNL1:
                begin
                    valid_reg[cur_reg[AW-1:0]] <= 1'b0;
                    if (pv_reg == '0) head_reg <= nx_reg;
                    if (nx_reg == '0) tail_reg <= pv_reg;
                    state_reg <= S_UNL2;
                end
                S_UNL2:
                begin
                    count_reg <= count_reg - ID_W'(1);
                    cur_reg   <= head_reg;
                    steps_reg <= '0;
                    state_reg <= S_EX_RD;
                end
                S_EX_RD:
                begin
                    if (steps_reg == '0)
                    begin
                        hi_reg <= '0; lo_reg <= SENTINEL_VALUE;
                        hid_reg <= cur_reg; lid_reg <= cur_reg;
                    end
                    if (steps_reg >= (AW+1)'(NODES) || cur_reg == '0)
                    begin
                        largest_reg  <= (steps_reg == '0) ? cur_reg : hid_reg;
                        smallest_reg <= (steps_reg == '0) ? cur_reg : lid_reg;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EX_CHK;
                    end
                end
                S_EX_CHK:
                begin
                    if (nv_q >= hi_reg || steps_reg == '0)
                    begin
                        hi_reg <= nv_q; hid_reg <= cur_reg;
                    end
                    if (nv_q <= lo_reg || steps_reg == '0)
                    begin
                        lo_reg <= nv_q; lid_reg <= cur_reg;
                    end
                    cur_reg   <= nl_q;
                    steps_reg <= steps_reg + (AW+1)'(1);
                    state_reg <= S_EX_RD;
                end
                S_READ_RD:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    rval_reg  <= nv_q;
                    rnx_reg   <= (req_reg.node_id == '0) ? head_reg : nl_q;
                    rpv_reg   <= (req_reg.node_id == '0) ? tail_reg : pl_q;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        status        <= st_reg;
                        result_id     <= rid_reg;
                        read_value    <= rval_reg;
                        read_next     <= rnx_reg;
                        read_prior    <= rpv_reg;
                        head_id       <= head_reg;
                        node_count    <= count_reg;
                        max_id        <= largest_reg;
                        min_id        <= smallest_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/pooled_sorted_linked_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_sorted_linked_list_core: doubly linked list in a fixed node pool
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | operation, item_value, sort_key, node_id
// m_axis  | out | status, result_id, read_value, read_next, read_prior,
//         |     | head_id, node_count, max_id, min_id
//
// The free-slot scan checks one slot a cycle; the sorted walk and the max/min
// walk step node by node on the single read port of the link and value
// memories.
// Reset clears links through per-slot valid bits; no clearing pass.
// A two-entry queue lets requests arrive while the engine works; a held
// result only stalls the engine at the end of the next request.
// ----------------------------------------------------------------------------
module pooled_sorted_linked_list_core
    import psll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // operation, item_value, sort_key, node_id
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata   // status, result_id, read_value, read_next,
                                        // read_prior, head_id, node_count, max_id, min_id
);

    req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  result_id, read_next, read_prior, head_id, node_count, max_id, min_id;
    logic [VAL_W-1:0] read_value;

    always_comb
    begin
        in_req.op          = op_t'(s_axis_tdata[2:0]);
        in_req.item_value  = s_axis_tdata[34:3];
        in_req.sort_key    = s_axis_tdata[66:35];
        in_req.node_id     = s_axis_tdata[74:67];
        in_req.id_range_ok = 1'b0;
    end

    psll_front #(.NODES(NODES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

    psll_back #(.NODES(NODES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .status(status),
        .result_id(result_id), .read_value(read_value), .read_next(read_next),
        .read_prior(read_prior), .head_id(head_id), .node_count(node_count),
        .max_id(max_id), .min_id(min_id));

    assign m_axis_tdata = {6'd0, min_id, max_id, node_count, head_id, read_prior,
                           read_next, read_value, result_id, status};

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status != 2'd3)) else $error("bad status");
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status != ST_OK) |-> (result_id == '0)) else $error("id on failure");
    a_empty_heads: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && node_count == '0) |-> (head_id == '0 && max_id == '0))
        else $error("empty list with head");

endmodule
